// ----- src/bpa_pkg.sv -----
// Shared types, constants and reset-image functions for the buddy page allocator.
// Depends on nothing; the allocator top level and the testbench import it.
`timescale 1ns / 1ps

package bpa_pkg;

	localparam int NUM_PAGES  = 1024;
	localparam int MAX_ORDER  = 8;
	localparam int PAGE_SHIFT = 12;

	localparam int PG_W   = $clog2(NUM_PAGES);
	localparam int LINK_W = $clog2(NUM_PAGES + 1);
	localparam int XW     = ((PG_W > MAX_ORDER + 1) ? PG_W : MAX_ORDER + 1) + 1;
	localparam int OW     = $clog2(MAX_ORDER + 1);
	localparam int ST_W   = 4;

	localparam logic [ST_W-1:0]   ST_GROUPED  = 4'd13;
	localparam logic [ST_W-1:0]   ST_OCCUPIED = 4'd14;
	localparam logic [ST_W-1:0]   ST_RESERVED = 4'd15;
	localparam logic [ST_W-1:0]   MAX_ST      = ST_W'(MAX_ORDER);
	localparam logic [LINK_W-1:0] NIL         = LINK_W'(NUM_PAGES);

	localparam int BLK_PAGES  = 1 << MAX_ORDER;
	localparam int FULL_PAGES = (NUM_PAGES / BLK_PAGES) * BLK_PAGES;
	localparam int REM_PAGES  = NUM_PAGES - FULL_PAGES;

	localparam logic [1:0] FN_ALLOC   = 2'd0;
	localparam logic [1:0] FN_FREE    = 2'd1;
	localparam logic [1:0] FN_RESERVE = 2'd2;
	localparam logic [1:0] FN_QUERY   = 2'd3;

	localparam logic [2:0] RS_OK        = 3'd0;
	localparam logic [2:0] RS_NOSPACE   = 3'd1;
	localparam logic [2:0] RS_UNALIGNED = 3'd2;
	localparam logic [2:0] RS_NOTALLOC  = 3'd3;
	localparam logic [2:0] RS_GROUPED   = 3'd4;
	localparam logic [2:0] RS_RANGE     = 3'd5;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] size_bytes;
		logic [31:0] page_address;
	} bpa_req_t;

	typedef struct packed {
		logic [2:0]  result_status;
		logic [31:0] block_address;
		logic        is_taken;
	} bpa_rsp_t;

	// page status after reset: largest aligned blocks from page 0 upward
	function automatic logic [ST_W-1:0] init_state(input logic [PG_W-1:0] i);
		int base;
		logic [ST_W-1:0] r;
		r = ST_GROUPED;
		base = FULL_PAGES;
		if (int'(i) < FULL_PAGES) begin
			if ((i & PG_W'(BLK_PAGES - 1)) == '0) r = MAX_ST;
		end else begin
			for (int o = MAX_ORDER - 1; o >= 0; o--) begin
				if (REM_PAGES[o]) begin
					if (int'(i) == base) r = ST_W'(o);
					base = base + (1 << o);
				end
			end
		end
		return r;
	endfunction

	function automatic logic [LINK_W-1:0] init_next(input logic [PG_W-1:0] i);
		logic [LINK_W-1:0] r;
		r = NIL;
		if (int'(i) < FULL_PAGES && (i & PG_W'(BLK_PAGES - 1)) == '0 &&
				int'(i) >= BLK_PAGES)
			r = LINK_W'(int'(i) - BLK_PAGES);
		return r;
	endfunction

	function automatic logic [LINK_W-1:0] init_prev(input logic [PG_W-1:0] i);
		logic [LINK_W-1:0] r;
		r = NIL;
		if (int'(i) < FULL_PAGES && (i & PG_W'(BLK_PAGES - 1)) == '0 &&
				int'(i) + BLK_PAGES < FULL_PAGES)
			r = LINK_W'(int'(i) + BLK_PAGES);
		return r;
	endfunction

	function automatic logic [LINK_W-1:0] init_head(input int o);
		int base;
		logic [LINK_W-1:0] r;
		r = NIL;
		base = FULL_PAGES;
		if (o == MAX_ORDER) begin
			if (FULL_PAGES > 0) r = LINK_W'(FULL_PAGES - BLK_PAGES);
		end else begin
			for (int oo = MAX_ORDER - 1; oo >= 0; oo--) begin
				if (REM_PAGES[oo]) begin
					if (oo == o) r = LINK_W'(base);
					base = base + (1 << oo);
				end
			end
		end
		return r;
	endfunction

endpackage

// ----- src/bpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module bpa_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [0:D-1];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- src/buddy_page_allocator.sv -----
// Top level of the buddy page allocator: sequencer, list heads and three page RAMs.
// Depends on bpa_pkg and bpa_ram.
//
//   channel   direction  signals            handshake
//   request   in         start, req         taken when start & !busy
//   result    out        done, rsp          one-cycle strobe, no backpressure
//
// One sequencer drives every page RAM access; RAM read data is registered.
// Query walks down grouped pages to the block head. Alloc pops a block, then splits it.
// Free checks occupancy, then merges level by level, unlinking a free buddy from its list.
// Reserve: pass one walks to the head of each containing block; pass two walks to
// the block of each chunk, unlinks it and splits it down, pushing the unused halves.
// After reset the block sweeps all NUM_PAGES (1024) pages of the page RAMs to their
// start image with busy high; rsp keeps each result until the next request is taken.
`timescale 1ns / 1ps

module buddy_page_allocator
	import bpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  bpa_req_t req,
	output logic     done,
	output bpa_rsp_t rsp
);

	localparam logic [4:0] S_INIT     = 5'd0;
	localparam logic [4:0] S_IDLE     = 5'd1;
	localparam logic [4:0] S_BO_RD    = 5'd2;
	localparam logic [4:0] S_BO_CK    = 5'd3;
	localparam logic [4:0] S_PU_A     = 5'd4;
	localparam logic [4:0] S_PU_B     = 5'd5;
	localparam logic [4:0] S_UL_RD    = 5'd6;
	localparam logic [4:0] S_UL_A     = 5'd7;
	localparam logic [4:0] S_UL_B     = 5'd8;
	localparam logic [4:0] S_Q_FIN    = 5'd9;
	localparam logic [4:0] S_AL_FIND  = 5'd10;
	localparam logic [4:0] S_AL_SPLIT = 5'd11;
	localparam logic [4:0] S_FR_RD0   = 5'd12;
	localparam logic [4:0] S_FR_CK0   = 5'd13;
	localparam logic [4:0] S_FR_RD    = 5'd14;
	localparam logic [4:0] S_FR_CK    = 5'd15;
	localparam logic [4:0] S_FR_MRG   = 5'd16;
	localparam logic [4:0] S_RV_P1    = 5'd17;
	localparam logic [4:0] S_RV_P1C   = 5'd18;
	localparam logic [4:0] S_RV_P2    = 5'd19;
	localparam logic [4:0] S_RV_P2C   = 5'd20;
	localparam logic [4:0] S_RV_P2D   = 5'd21;
	localparam logic [4:0] S_RV_SP    = 5'd22;
	localparam logic [4:0] S_FIN_OK   = 5'd23;

	localparam logic [32:0] NP33  = 33'(NUM_PAGES);
	localparam logic [XW-1:0] NPX = XW'(NUM_PAGES);

	// control state
	logic [4:0]        state_q, state_d, ret_q, ret_d;
	logic [PG_W-1:0]   cnt_q, cnt_d;
	logic [LINK_W-1:0] head_q [0:MAX_ORDER];
	logic [LINK_W-1:0] head_d [0:MAX_ORDER];
	logic              done_q, done_d;

	// working registers
	bpa_rsp_t        rsp_q, rsp_d;
	logic [OW-1:0]   ord_q, ord_d, lv_q, lv_d, sl_q, sl_d, k_q, k_d;
	logic [XW-1:0]   t_q, t_d, bud_q, bud_d, sb_q, sb_d, bi_q, bi_d;
	logic [XW-1:0]   p_q, p_d, s_q, s_d, e_q, e_d;
	logic [ST_W-1:0] bst_q, bst_d;

	// RAM ports
	logic            ps_we, nx_we, pv_we;
	logic [XW-1:0]   ps_wa, nx_wa, pv_wa, ps_ra, lk_ra;
	logic [ST_W-1:0] ps_wd, ps_rd;
	logic [LINK_W-1:0] nx_wd, pv_wd, nx_rd, pv_rd;

	bpa_ram #(.W(ST_W), .D(NUM_PAGES)) u_state_ram (
		.clk(clk), .we(ps_we), .waddr(ps_wa[PG_W-1:0]), .wdata(ps_wd),
		.raddr(ps_ra[PG_W-1:0]), .rdata(ps_rd)
	);

	bpa_ram #(.W(LINK_W), .D(NUM_PAGES)) u_next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_wa[PG_W-1:0]), .wdata(nx_wd),
		.raddr(lk_ra[PG_W-1:0]), .rdata(nx_rd)
	);

	bpa_ram #(.W(LINK_W), .D(NUM_PAGES)) u_prev_ram (
		.clk(clk), .we(pv_we), .waddr(pv_wa[PG_W-1:0]), .wdata(pv_wd),
		.raddr(lk_ra[PG_W-1:0]), .rdata(pv_rd)
	);

	// request decode
	logic [31-PAGE_SHIFT:0] pidx_c;
	logic [32:0]            pg33_c, m33_c, end33_c, e33_c;
	logic [5:0]             ordc;
	logic                   pidx_oor;

	always_comb begin
		pidx_c   = req.page_address[31:PAGE_SHIFT];
		pidx_oor = 33'(pidx_c) >= NP33;
		pg33_c   = ({1'b0, req.size_bytes} + 33'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT;
		m33_c    = pg33_c - 33'd1;
		end33_c  = {1'b0, req.page_address} + {1'b0, req.size_bytes} - 33'd1;
		e33_c    = end33_c >> PAGE_SHIFT;
		ordc     = '0;
		for (int i = 0; i < 33; i++) begin
			if (m33_c[i]) ordc = 6'(i + 1);
		end
	end

	// largest aligned chunk at p that stays within the range
	logic [XW:0]   rem_c;
	logic [OW-1:0] kc;

	always_comb begin
		rem_c = {1'b0, e_q} - {1'b0, p_q} + (XW+1)'(1);
		kc    = '0;
		for (int kk = 1; kk <= MAX_ORDER; kk++) begin
			if ((p_q & XW'((1 << kk) - 1)) == '0 && (XW+1)'(1 << kk) <= rem_c)
				kc = OW'(kk);
		end
	end

	// smallest nonempty list at or above the requested order
	logic          fnd;
	logic [OW-1:0] fl;

	always_comb begin
		fnd = 1'b0;
		fl  = '0;
		for (int o = MAX_ORDER; o >= 0; o--) begin
			if (OW'(o) >= ord_q && head_q[o] != NIL) begin
				fnd = 1'b1;
				fl  = OW'(o);
			end
		end
	end

	// sequencer
	logic [OW-1:0] lvm;
	logic [XW-1:0] bud, oth, hn, np;
	logic          inr, merge;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cnt_d   = cnt_q;
		head_d  = head_q;
		done_d  = 1'b0;
		rsp_d   = rsp_q;
		ord_d   = ord_q;
		lv_d    = lv_q;
		sl_d    = sl_q;
		k_d     = k_q;
		t_d     = t_q;
		bud_d   = bud_q;
		sb_d    = sb_q;
		bi_d    = bi_q;
		p_d     = p_q;
		s_d     = s_q;
		e_d     = e_q;
		bst_d   = bst_q;
		ps_we = 1'b0; ps_wa = '0; ps_wd = '0; ps_ra = '0;
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0; lk_ra = '0;
		lvm = lv_q - OW'(1);
		bud = '0; oth = '0; hn = '0; np = '0;
		inr = 1'b0; merge = 1'b0;

		unique case (state_q)
			S_INIT: begin
				// sweep the page RAMs to the reset image
				ps_we = 1'b1; ps_wa = XW'(cnt_q); ps_wd = init_state(cnt_q);
				nx_we = 1'b1; nx_wa = XW'(cnt_q); nx_wd = init_next(cnt_q);
				pv_we = 1'b1; pv_wa = XW'(cnt_q); pv_wd = init_prev(cnt_q);
				cnt_d = cnt_q + PG_W'(1);
				if (cnt_q == PG_W'(NUM_PAGES - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					rsp_d = '0;
					unique case (req.func)
						FN_ALLOC: begin
							if (req.size_bytes == '0 || ordc > 6'(MAX_ORDER)) begin
								rsp_d.result_status = RS_NOSPACE;
								done_d = 1'b1;
							end else begin
								ord_d   = OW'(ordc);
								state_d = S_AL_FIND;
							end
						end
						FN_FREE: begin
							if (req.page_address[PAGE_SHIFT-1:0] != '0) begin
								rsp_d.result_status = RS_UNALIGNED;
								done_d = 1'b1;
							end else if (pidx_oor) begin
								rsp_d.result_status = RS_RANGE;
								done_d = 1'b1;
							end else begin
								t_d     = XW'(pidx_c);
								state_d = S_FR_RD0;
							end
						end
						FN_RESERVE: begin
							if (req.size_bytes == '0) begin
								rsp_d.result_status = RS_NOSPACE;
								done_d = 1'b1;
							end else if (pidx_oor || e33_c >= NP33) begin
								rsp_d.result_status = RS_RANGE;
								done_d = 1'b1;
							end else begin
								s_d     = XW'(pidx_c);
								p_d     = XW'(pidx_c);
								e_d     = XW'(e33_c);
								state_d = S_RV_P1;
							end
						end
						FN_QUERY: begin
							if (pidx_oor) begin
								rsp_d.result_status = RS_RANGE;
								done_d = 1'b1;
							end else begin
								bi_d    = XW'(pidx_c);
								ret_d   = S_Q_FIN;
								state_d = S_BO_RD;
							end
						end
						default: ;
					endcase
				end
			end
			// walk down through grouped pages to the block head
			S_BO_RD: begin
				ps_ra   = bi_q;
				state_d = S_BO_CK;
			end
			S_BO_CK: begin
				if (ps_rd == ST_GROUPED && bi_q != '0) begin
					bi_d    = bi_q & (bi_q - XW'(1));
					state_d = S_BO_RD;
				end else begin
					bst_d   = ps_rd;
					state_d = ret_q;
				end
			end
			// push sb onto list sl
			S_PU_A: begin
				nx_we = 1'b1; nx_wa = sb_q; nx_wd = head_q[sl_q];
				pv_we = 1'b1; pv_wa = sb_q; pv_wd = NIL;
				state_d = S_PU_B;
			end
			S_PU_B: begin
				if (head_q[sl_q] != NIL) begin
					pv_we = 1'b1; pv_wa = XW'(head_q[sl_q]); pv_wd = LINK_W'(sb_q);
				end
				head_d[sl_q] = LINK_W'(sb_q);
				state_d = ret_q;
			end
			// unlink sb from list sl
			S_UL_RD: begin
				lk_ra   = sb_q;
				state_d = S_UL_A;
			end
			S_UL_A: begin
				if (XW'(head_q[sl_q]) == sb_q) head_d[sl_q] = nx_rd;
				if (pv_rd != NIL) begin
					nx_we = 1'b1; nx_wa = XW'(pv_rd); nx_wd = nx_rd;
				end
				if (nx_rd != NIL) begin
					pv_we = 1'b1; pv_wa = XW'(nx_rd); pv_wd = pv_rd;
				end
				state_d = S_UL_B;
			end
			S_UL_B: begin
				nx_we = 1'b1; nx_wa = sb_q; nx_wd = NIL;
				pv_we = 1'b1; pv_wa = sb_q; pv_wd = NIL;
				state_d = ret_q;
			end
			S_Q_FIN: begin
				rsp_d.is_taken = (bst_q == ST_OCCUPIED);
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_FIN_OK: begin
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			// allocate: pop, then split down pushing the upper halves
			S_AL_FIND: begin
				if (!fnd) begin
					rsp_d.result_status = RS_NOSPACE;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					t_d     = XW'(head_q[fl]);
					lv_d    = fl;
					sb_d    = XW'(head_q[fl]);
					sl_d    = fl;
					ret_d   = S_AL_SPLIT;
					state_d = S_UL_RD;
				end
			end
			S_AL_SPLIT: begin
				if (lv_q > ord_q) begin
					bud  = t_q ^ (XW'(1) << lvm);
					lv_d = lvm;
					if (bud < NPX) begin
						ps_we = 1'b1; ps_wa = bud; ps_wd = ST_W'(lvm);
						sb_d    = bud;
						sl_d    = lvm;
						ret_d   = S_AL_SPLIT;
						state_d = S_PU_A;
					end
				end else begin
					ps_we = 1'b1; ps_wa = t_q; ps_wd = ST_OCCUPIED;
					rsp_d.block_address = 32'(t_q) << PAGE_SHIFT;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			// free: check occupancy, then merge upward
			S_FR_RD0: begin
				ps_ra   = t_q;
				state_d = S_FR_CK0;
			end
			S_FR_CK0: begin
				if (ps_rd != ST_OCCUPIED) begin
					rsp_d.result_status = RS_NOTALLOC;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					lv_d    = '0;
					state_d = S_FR_RD;
				end
			end
			S_FR_RD: begin
				bud   = t_q ^ (XW'(1) << lv_q);
				bud_d = bud;
				if (bud < NPX) ps_ra = bud;
				state_d = S_FR_CK;
			end
			S_FR_CK: begin
				inr   = bud_q < NPX;
				merge = inr && (ps_rd == ST_W'(lv_q) || ps_rd == ST_GROUPED);
				if (inr && bud_q < t_q && ps_rd == ST_GROUPED) begin
					// lower buddy inside a larger block: merges so far stand
					rsp_d.result_status = RS_GROUPED;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (!merge || lv_q == OW'(MAX_ORDER)) begin
					ps_we = 1'b1; ps_wa = t_q; ps_wd = ST_W'(lv_q);
					sb_d    = t_q;
					sl_d    = lv_q;
					ret_d   = S_FIN_OK;
					state_d = S_PU_A;
				end else if (ps_rd == ST_W'(lv_q)) begin
					sb_d    = bud_q;
					sl_d    = lv_q;
					ret_d   = S_FR_MRG;
					state_d = S_UL_RD;
				end else begin
					state_d = S_FR_MRG;
				end
			end
			S_FR_MRG: begin
				ps_we = 1'b1;
				ps_wd = ST_GROUPED;
				if (bud_q > t_q) begin
					ps_wa = bud_q;
				end else begin
					ps_wa = t_q;
					t_d   = bud_q;
				end
				lv_d    = lv_q + OW'(1);
				state_d = S_FR_RD;
			end
			// reserve, first pass: every containing block must be free
			S_RV_P1: begin
				if (p_q > e_q) begin
					p_d     = s_q;
					state_d = S_RV_P2;
				end else begin
					bi_d    = p_q;
					ret_d   = S_RV_P1C;
					state_d = S_BO_RD;
				end
			end
			S_RV_P1C: begin
				if (bst_q > MAX_ST) begin
					rsp_d.result_status = RS_NOSPACE;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					np = bi_q + (XW'(1) << bst_q);
					if (np <= p_q) np = p_q + XW'(1);
					p_d     = np;
					state_d = S_RV_P1;
				end
			end
			// reserve, second pass: carve chunks
			S_RV_P2: begin
				if (p_q > e_q) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					k_d     = kc;
					bi_d    = p_q;
					ret_d   = S_RV_P2C;
					state_d = S_BO_RD;
				end
			end
			S_RV_P2C: begin
				if (bst_q > MAX_ST) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					t_d     = bi_q;
					lv_d    = OW'(bst_q);
					sb_d    = bi_q;
					sl_d    = OW'(bst_q);
					ret_d   = S_RV_P2D;
					state_d = S_UL_RD;
				end
			end
			S_RV_P2D: begin
				if (lv_q <= k_q) begin
					ps_we = 1'b1; ps_wa = t_q; ps_wd = ST_RESERVED;
					np = t_q + (XW'(1) << lv_q);
					if (np <= p_q) np = p_q + XW'(1);
					p_d     = np;
					state_d = S_RV_P2;
				end else begin
					state_d = S_RV_SP;
				end
			end
			S_RV_SP: begin
				if (lv_q > k_q) begin
					bud = t_q ^ (XW'(1) << lvm);
					if (p_q >= bud) begin
						oth = t_q;
						hn  = bud;
					end else begin
						oth = bud;
						hn  = t_q;
					end
					t_d  = hn;
					lv_d = lvm;
					if (oth < NPX) begin
						ps_we = 1'b1; ps_wa = oth; ps_wd = ST_W'(lvm);
						sb_d    = oth;
						sl_d    = lvm;
						ret_d   = S_RV_SP;
						state_d = S_PU_A;
					end
				end else begin
					if (t_q < NPX) begin
						ps_we = 1'b1; ps_wa = t_q; ps_wd = ST_RESERVED;
					end
					p_d     = p_q + (XW'(1) << k_q);
					state_d = S_RV_P2;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (done_d) state_d = S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			for (int o = 0; o <= MAX_ORDER; o++) head_q[o] <= init_head(o);
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
			head_q  <= head_d;
		end
	end

	// hold working values; no reset needed
	always_ff @(posedge clk) begin
		ret_q <= ret_d;
		rsp_q <= rsp_d;
		ord_q <= ord_d;
		lv_q  <= lv_d;
		sl_q  <= sl_d;
		k_q   <= k_d;
		t_q   <= t_d;
		bud_q <= bud_d;
		sb_q  <= sb_d;
		bi_q  <= bi_d;
		p_q   <= p_d;
		s_q   <= s_d;
		e_q   <= e_d;
		bst_q <= bst_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- sim/buddy_page_allocator_tb.sv -----
// Self-checking testbench for buddy_page_allocator: a directed opening, then random requests.
// Its own allocator model predicts each result. Depends on bpa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module buddy_page_allocator_tb;
	import bpa_pkg::*;

	localparam longint PG_BYTES = 64'd1 << PAGE_SHIFT;
	localparam int RAND_REQS = 400;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	bpa_req_t req = '0;
	logic     done;
	bpa_rsp_t rsp;

	buddy_page_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #1 clk = ~clk;

	// model of the page table and free lists
	logic [ST_W-1:0]   pg_st [NUM_PAGES];
	logic [LINK_W-1:0] pg_next [NUM_PAGES];
	logic [LINK_W-1:0] pg_prev [NUM_PAGES];
	logic [LINK_W-1:0] free_head [MAX_ORDER+1];

	bpa_req_t    pending_reqs [$];
	bpa_rsp_t    expected_rsps [$];
	logic [31:0] live_blocks [$];
	int          idle_pct = 0;
	bit          failed = 1'b0;
	bpa_rsp_t    want;

	function automatic void list_push(int b, int lv);
		int h;
		h = free_head[lv];
		pg_next[b] = LINK_W'(h);
		pg_prev[b] = NIL;
		if (h < NUM_PAGES) pg_prev[h] = LINK_W'(b);
		free_head[lv] = LINK_W'(b);
	endfunction

	function automatic void list_unlink(int b, int lv);
		int n, p;
		n = pg_next[b];
		p = pg_prev[b];
		if (free_head[lv] == LINK_W'(b)) free_head[lv] = LINK_W'(n);
		if (p < NUM_PAGES) pg_next[p] = LINK_W'(n);
		if (n < NUM_PAGES) pg_prev[n] = LINK_W'(p);
		pg_next[b] = NIL;
		pg_prev[b] = NIL;
	endfunction

	function automatic int head_page(int i);
		while (pg_st[i] == ST_GROUPED && i != 0) i = i & (i - 1);
		return i;
	endfunction

	function automatic void table_reset();
		int i, o;
		i = 0;
		for (int j = 0; j < NUM_PAGES; j++) begin
			pg_st[j] = ST_GROUPED;
			pg_next[j] = NIL;
			pg_prev[j] = NIL;
		end
		for (int j = 0; j <= MAX_ORDER; j++) free_head[j] = NIL;
		while (i < NUM_PAGES) begin
			o = MAX_ORDER;
			while (o > 0 && ((i & ((1 << o) - 1)) != 0 || i + (1 << o) > NUM_PAGES)) o--;
			pg_st[i] = ST_W'(o);
			list_push(i, o);
			i += 1 << o;
		end
	endfunction

	function automatic logic [2:0] carve_alloc(logic [31:0] size, output logic [31:0] addr);
		longint m;
		int ord, lv, b, bud;
		addr = '0;
		ord = 0;
		if (size == 0) return RS_NOSPACE;
		m = ((longint'(size) + PG_BYTES - 1) >> PAGE_SHIFT) - 1;
		while (m != 0) begin
			m >>= 1;
			ord++;
		end
		if (ord > MAX_ORDER) return RS_NOSPACE;
		for (lv = ord; lv <= MAX_ORDER; lv++)
			if (free_head[lv] < NUM_PAGES) break;
		if (lv > MAX_ORDER) return RS_NOSPACE;
		b = free_head[lv];
		list_unlink(b, lv);
		while (lv > ord) begin
			lv--;
			bud = b ^ (1 << lv);
			if (bud < NUM_PAGES) begin
				pg_st[bud] = ST_W'(lv);
				list_push(bud, lv);
			end
		end
		pg_st[b] = ST_OCCUPIED;
		addr = 32'(longint'(b) << PAGE_SHIFT);
		return RS_OK;
	endfunction

	function automatic logic [2:0] merge_free(logic [31:0] addr);
		int t, bud;
		bit inr, mrg;
		if ((longint'(addr) & (PG_BYTES - 1)) != 0) return RS_UNALIGNED;
		if ((longint'(addr) >> PAGE_SHIFT) >= NUM_PAGES) return RS_RANGE;
		t = int'(addr >> PAGE_SHIFT);
		if (pg_st[t] != ST_OCCUPIED) return RS_NOTALLOC;
		for (int lv = 0; lv <= MAX_ORDER; lv++) begin
			bud = t ^ (1 << lv);
			inr = bud < NUM_PAGES;
			if (inr && bud < t && pg_st[bud] == ST_GROUPED) return RS_GROUPED;
			mrg = inr && (pg_st[bud] == ST_W'(lv) || pg_st[bud] == ST_GROUPED);
			if (!mrg || lv == MAX_ORDER) begin
				pg_st[t] = ST_W'(lv);
				list_push(t, lv);
				return RS_OK;
			end
			if (pg_st[bud] == ST_W'(lv)) list_unlink(bud, lv);
			if (bud > t) pg_st[bud] = ST_GROUPED;
			else begin
				pg_st[t] = ST_GROUPED;
				t = bud;
			end
		end
		return RS_OK;
	endfunction

	function automatic logic [2:0] mark_reserved(logic [31:0] addr, logic [31:0] size);
		longint s, e, p, np;
		int h, st, k, cur, upper, other;
		if (size == 0) return RS_NOSPACE;
		s = longint'(addr) >> PAGE_SHIFT;
		e = (longint'(addr) + longint'(size) - 1) >> PAGE_SHIFT;
		if (s >= NUM_PAGES || e >= NUM_PAGES) return RS_RANGE;
		// first pass: every page of the range must sit in a free block
		for (p = s; p <= e; p = np) begin
			h = head_page(int'(p));
			st = pg_st[h];
			if (st > MAX_ORDER) return RS_NOSPACE;
			np = longint'(h) + (64'd1 << st);
			if (np <= p) np = p + 1;
		end
		for (p = s; p <= e; p = np) begin
			k = MAX_ORDER;
			while (k > 0 && ((p & ((64'd1 << k) - 1)) != 0 || (64'd1 << k) > e - p + 1)) k--;
			h = head_page(int'(p));
			st = pg_st[h];
			if (st > MAX_ORDER) break;
			list_unlink(h, st);
			if (st <= k) begin
				pg_st[h] = ST_RESERVED;
				np = longint'(h) + (64'd1 << st);
				if (np <= p) np = p + 1;
				continue;
			end
			cur = st;
			while (cur > k) begin
				cur--;
				upper = h ^ (1 << cur);
				if (p >= upper) begin
					other = h;
					h = upper;
				end else other = upper;
				if (other < NUM_PAGES) begin
					pg_st[other] = ST_W'(cur);
					list_push(other, cur);
				end
			end
			if (h < NUM_PAGES) pg_st[h] = ST_RESERVED;
			np = p + (64'd1 << k);
		end
		return RS_OK;
	endfunction

	// apply one accepted request to the model and return the result it must give
	function automatic bpa_rsp_t predict_response(bpa_req_t r);
		bpa_rsp_t o;
		logic [31:0] a;
		o = '0;
		case (r.func)
			FN_ALLOC: begin
				o.result_status = carve_alloc(r.size_bytes, a);
				o.block_address = a;
				if (o.result_status == RS_OK) live_blocks.push_back(a);
			end
			FN_FREE: o.result_status = merge_free(r.page_address);
			FN_RESERVE: o.result_status = mark_reserved(r.page_address, r.size_bytes);
			default: begin
				if ((longint'(r.page_address) >> PAGE_SHIFT) >= NUM_PAGES)
					o.result_status = RS_RANGE;
				else begin
					o.result_status = RS_OK;
					o.is_taken = pg_st[head_page(int'(r.page_address >> PAGE_SHIFT))]
						== ST_OCCUPIED;
				end
			end
		endcase
		return o;
	endfunction

	// Driver: predict on acceptance, then present the next request or idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) expected_rsps.push_back(predict_response(req));
			if (!start || !busy) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
					req <= pending_reqs.pop_front();
					start <= 1'b1;
				end else start <= 1'b0;
			end
		end
	end

	// Monitor: each strobe is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				$error("result with nothing expected: status %0d", rsp.result_status);
				failed = 1'b1;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.result_status !== want.result_status) begin
					$error("result_status expected %0d got %0d",
						want.result_status, rsp.result_status);
					failed = 1'b1;
				end
				if (rsp.block_address !== want.block_address) begin
					$error("block_address expected %h got %h",
						want.block_address, rsp.block_address);
					failed = 1'b1;
				end
				if (rsp.is_taken !== want.is_taken) begin
					$error("is_taken expected %0d got %0d", want.is_taken, rsp.is_taken);
					failed = 1'b1;
				end
			end
		end
	end

	function automatic bpa_req_t mk(logic [1:0] f, logic [31:0] sz, logic [31:0] ad);
		bpa_req_t r;
		r.func = f;
		r.size_bytes = sz;
		r.page_address = ad;
		return r;
	endfunction

	function automatic logic [31:0] take_live();
		int i;
		logic [31:0] a;
		i = $urandom_range(live_blocks.size() - 1);
		a = live_blocks[i];
		live_blocks.delete(i);
		return a;
	endfunction

	function automatic bpa_req_t random_req();
		int r, pick;
		logic [31:0] sz;
		r = $urandom_range(99);
		if (r < 42 || (r < 75 && live_blocks.size() == 0)) begin
			pick = $urandom_range(99);
			if (pick < 70) sz = $urandom_range(4 * 4096, 1);
			else if (pick < 88) sz = $urandom_range(64 * 4096, 1);
			else if (pick < 95) sz = $urandom_range(300 * 4096, 1);
			else sz = $urandom();
			return mk(FN_ALLOC, sz, $urandom());
		end
		if (r < 75) begin
			// mostly genuine frees; a few stray or repeated addresses
			pick = $urandom_range(99);
			if (pick < 85) return mk(FN_FREE, $urandom(), take_live());
			if (pick < 93)
				return mk(FN_FREE, $urandom(), 32'($urandom_range(NUM_PAGES - 1)) << PAGE_SHIFT);
			return mk(FN_FREE, $urandom(), $urandom());
		end
		if (r < 80)
			return mk(FN_RESERVE, $urandom_range(3 * 4096, 1),
				$urandom_range(NUM_PAGES * 4096 - 1));
		if (r < 83) return mk(FN_RESERVE, $urandom(), $urandom());
		if (r < 93 && live_blocks.size() != 0)
			return mk(FN_QUERY, $urandom(), live_blocks[$urandom_range(live_blocks.size() - 1)]
				+ $urandom_range(4095));
		if (r < 98) return mk(FN_QUERY, $urandom(), $urandom_range(NUM_PAGES * 4096 - 1));
		return mk(FN_QUERY, $urandom(), $urandom());
	endfunction

	task automatic drain();
		while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0) @(posedge clk);
	endtask

	initial begin
		table_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening: size extremes, range and alignment errors, reserve cases
		pending_reqs.push_back(mk(FN_ALLOC, 32'd0, 32'd0));
		pending_reqs.push_back(mk(FN_ALLOC, 32'd1, 32'd0));
		pending_reqs.push_back(mk(FN_ALLOC, 32'hFFFF_FFFF, 32'd0));
		pending_reqs.push_back(mk(FN_ALLOC, 32'h0010_0001, 32'd0));
		pending_reqs.push_back(mk(FN_ALLOC, 32'h0010_0000, 32'd0));
		pending_reqs.push_back(mk(FN_ALLOC, 32'h0000_3000, 32'd0));
		pending_reqs.push_back(mk(FN_QUERY, 32'd0, 32'h0000_0000));
		pending_reqs.push_back(mk(FN_QUERY, 32'd0, 32'h003F_FFFF));
		pending_reqs.push_back(mk(FN_QUERY, 32'd0, 32'hFFFF_FFFF));
		pending_reqs.push_back(mk(FN_FREE, 32'd0, 32'h0000_0123));
		pending_reqs.push_back(mk(FN_FREE, 32'd0, 32'hFFFF_F001));
		pending_reqs.push_back(mk(FN_FREE, 32'd0, 32'h0040_0000));
		pending_reqs.push_back(mk(FN_FREE, 32'd0, 32'h0000_5000));
		pending_reqs.push_back(mk(FN_RESERVE, 32'd0, 32'h0001_0000));
		pending_reqs.push_back(mk(FN_RESERVE, 32'h0000_2000, 32'h003F_F000));
		pending_reqs.push_back(mk(FN_RESERVE, 32'h0000_1000, 32'hFFFF_F000));
		pending_reqs.push_back(mk(FN_RESERVE, 32'h0000_6800, 32'h0001_3000));
		pending_reqs.push_back(mk(FN_RESERVE, 32'h0000_1000, 32'h0001_3000));
		pending_reqs.push_back(mk(FN_FREE, 32'd0, 32'h0001_3000));
		drain();
		pending_reqs.push_back(mk(FN_QUERY, 32'd0, live_blocks[0] + 32'hFFF));
		pending_reqs.push_back(mk(FN_FREE, 32'd0, live_blocks[0]));
		pending_reqs.push_back(mk(FN_FREE, 32'd0, live_blocks[0]));
		live_blocks.delete(0);
		drain();

		// random part: four phases of sender idling, topped up as the driver drains
		for (int n = 0; n < RAND_REQS; n++) begin
			case (n / 100)
				1: idle_pct = 69;
				3: idle_pct = 35;
				default: idle_pct = 0;
			endcase
			while (pending_reqs.size() != 0) @(posedge clk);
			pending_reqs.push_back(random_req());
		end
		drain();
		repeat (200) @(posedge clk);
		if (!failed && expected_rsps.size() == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/bpa_pkg.sv
src/bpa_ram.sv
src/buddy_page_allocator.sv
sim/buddy_page_allocator_tb.sv
